### rtl/bcpe_pkg.sv
// Shared types, codes and widths for the Bezier curve point evaluator.
package bcpe_pkg;

    // Field widths fixed by the item formats
    localparam int CNT_W    = 5;
    localparam int IDX_W    = 4;
    localparam int COORD_W  = 10;
    localparam int T_W      = 17;

    // Binomial of degree up to 19 fits 17 bits; coefficient is binomial times coordinate
    localparam int BINOM_W  = 17;
    localparam int COEF_W   = BINOM_W + COORD_W;

    // Wide arithmetic runs one 32-bit limb at a time
    localparam int LIMB_BITS = 32;
    localparam int PROD_T_W  = LIMB_BITS + T_W;
    localparam int PROD_C_W  = LIMB_BITS + COEF_W;
    localparam int SUM_W     = PROD_C_W + 1;
    localparam int CARRY_W   = SUM_W - LIMB_BITS;
    localparam int UCARRY_W  = PROD_T_W - LIMB_BITS;

    localparam logic [T_W-1:0] ONE_Q16 = 17'h10000;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_EVAL = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [IDX_W-1:0]   point_index;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic [T_W-1:0]     t_param;
    } req_t;

    typedef struct packed {
        logic [COORD_W-1:0] curve_x;
        logic [COORD_W-1:0] curve_y;
    } res_t;

    typedef struct packed {
        logic [CNT_W-1:0] point_count;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASCAL,
        ST_COEF,
        ST_LIMB,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic             load;
        logic             start;
        logic             pascal;
        logic             coef;
        logic             mul;
        logic             add;
        logic             emit;
        logic [CNT_W-1:0] step;
        logic [CNT_W-1:0] mul_limb;
        logic [CNT_W-1:0] add_limb;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [CNT_W-1:0] deg;
        logic             out_free;
    } stat_t;

endpackage

### rtl/bcpe_if.sv
// Handshake channel interfaces for request, result and setup transfers.
interface bcpe_req_if;
    import bcpe_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bcpe_res_if;
    import bcpe_pkg::*;
    logic valid;
    logic ready;
    res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bcpe_cfg_if;
    import bcpe_pkg::*;
    logic valid;
    logic ready;
    cfg_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/bcpe_ctrl.sv
// Sequencer: Pascal row build, per-step coefficient setup and limb passes.
module bcpe_ctrl #(
    parameter int MAX_POINTS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  bcpe_pkg::kind_t req_kind,
    output logic            req_ready,
    input  bcpe_pkg::stat_t stat,
    output bcpe_pkg::cmd_t  cmd
);
    import bcpe_pkg::*;

    localparam int NL = ((MAX_POINTS - 1) / 2) + 2;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] limb_cnt;

    // Limbs touched at step k: value stays below 2^(16k+48)
    assign limb_cnt = (k_reg >> 1) + CNT_W'(2);

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            j_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_kind == KIND_EVAL)
                    begin
                        cmd.start  = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_PASCAL;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_PASCAL:
            begin
                cmd.pascal = 1'b1;
                cnt_next   = cnt_reg + CNT_W'(1);
                if (cnt_reg == stat.deg - CNT_W'(1))
                begin
                    k_next     = '0;
                    state_next = ST_COEF;
                end
            end
            ST_COEF:
            begin
                cmd.coef   = 1'b1;
                cmd.step   = k_reg;
                j_next     = '0;
                state_next = ST_LIMB;
            end
            ST_LIMB:
            begin
                // products for limb j overlap the add for limb j-1
                cmd.step     = k_reg;
                cmd.mul      = (j_reg < limb_cnt);
                cmd.mul_limb = j_reg;
                cmd.add      = (j_reg != '0);
                cmd.add_limb = j_reg - CNT_W'(1);
                if (j_reg == limb_cnt)
                begin
                    if (k_reg == stat.deg)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = ST_COEF;
                    end
                end
                else
                begin
                    j_next = j_reg + CNT_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Checks
    a_limb_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul |-> cmd.mul_limb < CNT_W'(NL))
        else $error("limb index beyond wide registers");

    a_limb_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mul && cmd.add) |-> cmd.mul_limb != cmd.add_limb)
        else $error("product and add stages on the same limb");

    a_start_eval: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> (req_valid && req_kind == KIND_EVAL))
        else $error("evaluation started without an evaluate transfer");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result register overwritten before transfer");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.coef |-> cmd.step <= stat.deg)
        else $error("Horner step beyond curve degree");

endmodule

### rtl/bcpe_dp.sv
// Datapath: point store, Pascal row, limb-serial Horner accumulators, result register.
module bcpe_dp #(
    parameter int MAX_POINTS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  bcpe_pkg::cmd_t  cmd,
    output bcpe_pkg::stat_t stat,
    input  bcpe_pkg::req_t  req_data,
    input  logic            cfg_we,
    input  bcpe_pkg::cfg_t  cfg_data,
    input  logic            res_ready,
    output logic            res_valid,
    output bcpe_pkg::res_t  res_data
);
    import bcpe_pkg::*;

    localparam int NL     = ((MAX_POINTS - 1) / 2) + 2;
    localparam int SIDX_W = $clog2(MAX_POINTS);
    localparam int LIDX_W = $clog2(NL);
    localparam int FLAT_W = NL * LIMB_BITS;
    localparam int OFS_W  = $clog2(FLAT_W);

    logic [CNT_W-1:0]     pc_reg;
    logic [COORD_W-1:0]   store_x_reg [MAX_POINTS];
    logic [COORD_W-1:0]   store_y_reg [MAX_POINTS];
    logic [BINOM_W-1:0]   row_reg [MAX_POINTS];
    logic [CNT_W-1:0]     deg_reg;
    logic [T_W-1:0]       t_reg, u_reg;
    logic [COEF_W-1:0]    cx_reg, cy_reg;
    logic [LIMB_BITS-1:0] accx_reg [NL];
    logic [LIMB_BITS-1:0] accy_reg [NL];
    logic [LIMB_BITS-1:0] upow_reg [NL];
    logic [PROD_T_W-1:0]  pxt_reg, pyt_reg, puu_reg;
    logic [PROD_C_W-1:0]  pxc_reg, pyc_reg;
    logic [CARRY_W-1:0]   carry_x_reg, carry_y_reg;
    logic [UCARRY_W-1:0]  carry_u_reg;
    logic                 res_valid_reg;
    logic [COORD_W-1:0]   res_x_reg, res_y_reg;

    logic [CNT_W-1:0]     n_clamp;
    logic [CNT_W-1:0]     load_idx;
    logic                 load_ok;
    logic [T_W-1:0]       t_sat;
    logic [CNT_W-1:0]     src_idx;
    logic [LIDX_W-1:0]    mul_idx, add_idx;
    logic [SUM_W-1:0]     sum_x, sum_y;
    logic [PROD_T_W-1:0]  sum_u;
    logic [FLAT_W-1:0]    accx_flat, accy_flat;
    logic [OFS_W-1:0]     pix_ofs;

    // Point count clamped to the supported range
    always_comb
    begin
        if (pc_reg < CNT_W'(2))
            n_clamp = CNT_W'(2);
        else if (pc_reg > CNT_W'(MAX_POINTS))
            n_clamp = CNT_W'(MAX_POINTS);
        else
            n_clamp = pc_reg;
    end

    assign load_idx = CNT_W'(req_data.point_index);
    assign load_ok  = (load_idx < CNT_W'(MAX_POINTS));
    assign t_sat    = (req_data.t_param > ONE_Q16) ? ONE_Q16 : req_data.t_param;
    assign src_idx  = deg_reg - cmd.step;
    assign mul_idx  = cmd.mul_limb[LIDX_W-1:0];
    assign add_idx  = cmd.add_limb[LIDX_W-1:0];

    // Limb sums: new limb plus carry into the next one
    assign sum_x = SUM_W'(pxt_reg) + SUM_W'(pxc_reg) + SUM_W'(carry_x_reg);
    assign sum_y = SUM_W'(pyt_reg) + SUM_W'(pyc_reg) + SUM_W'(carry_y_reg);
    assign sum_u = puu_reg + PROD_T_W'(carry_u_reg);

    // Config register and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= CNT_W'(2);
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                pc_reg <= cfg_data.point_count;
            if (cmd.emit)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Control point store
    always_ff @(posedge clk)
    begin
        if (cmd.load && load_ok)
        begin
            store_x_reg[load_idx[SIDX_W-1:0]] <= req_data.point_x;
            store_y_reg[load_idx[SIDX_W-1:0]] <= req_data.point_y;
        end
    end

    // Evaluation setup and binomial row, one Pascal step per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            deg_reg <= n_clamp - CNT_W'(1);
            t_reg   <= t_sat;
            u_reg   <= ONE_Q16 - t_sat;
            for (int i = 0; i < MAX_POINTS; i++)
                row_reg[i] <= (i == 0) ? BINOM_W'(1) : '0;
        end
        else if (cmd.pascal)
        begin
            for (int i = 1; i < MAX_POINTS; i++)
                row_reg[i] <= row_reg[i] + row_reg[i-1];
        end
    end

    // Step coefficient C(deg,k) * p[deg-k]
    always_ff @(posedge clk)
    begin
        if (cmd.coef)
        begin
            cx_reg <= COEF_W'(row_reg[cmd.step[SIDX_W-1:0]])
                    * COEF_W'(store_x_reg[src_idx[SIDX_W-1:0]]);
            cy_reg <= COEF_W'(row_reg[cmd.step[SIDX_W-1:0]])
                    * COEF_W'(store_y_reg[src_idx[SIDX_W-1:0]]);
        end
    end

    // Limb products: acc*t, upow*u, upow*coef
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            pxt_reg <= PROD_T_W'(accx_reg[mul_idx]) * PROD_T_W'(t_reg);
            pyt_reg <= PROD_T_W'(accy_reg[mul_idx]) * PROD_T_W'(t_reg);
            puu_reg <= PROD_T_W'(upow_reg[mul_idx]) * PROD_T_W'(u_reg);
            pxc_reg <= PROD_C_W'(upow_reg[mul_idx]) * PROD_C_W'(cx_reg);
            pyc_reg <= PROD_C_W'(upow_reg[mul_idx]) * PROD_C_W'(cy_reg);
        end
    end

    // Accumulators: acc = acc*t + coef*u^k, upow = upow*u
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            for (int i = 0; i < NL; i++)
            begin
                accx_reg[i] <= '0;
                accy_reg[i] <= '0;
                upow_reg[i] <= (i == 0) ? LIMB_BITS'(1) : '0;
            end
        end
        else if (cmd.add)
        begin
            accx_reg[add_idx] <= sum_x[LIMB_BITS-1:0];
            accy_reg[add_idx] <= sum_y[LIMB_BITS-1:0];
            upow_reg[add_idx] <= sum_u[LIMB_BITS-1:0];
        end
    end

    // Carries restart at each step
    always_ff @(posedge clk)
    begin
        if (cmd.coef)
        begin
            carry_x_reg <= '0;
            carry_y_reg <= '0;
            carry_u_reg <= '0;
        end
        else if (cmd.add)
        begin
            carry_x_reg <= sum_x[SUM_W-1:LIMB_BITS];
            carry_y_reg <= sum_y[SUM_W-1:LIMB_BITS];
            carry_u_reg <= sum_u[PROD_T_W-1:LIMB_BITS];
        end
    end

    // Flattened accumulators for the final pixel extraction
    for (genvar g = 0; g < NL; g++)
    begin : g_flat
        assign accx_flat[g*LIMB_BITS +: LIMB_BITS] = accx_reg[g];
        assign accy_flat[g*LIMB_BITS +: LIMB_BITS] = accy_reg[g];
    end

    // Whole pixel sits above 16*deg fraction bits
    assign pix_ofs = OFS_W'({deg_reg, 4'b0000});

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_x_reg <= accx_flat[pix_ofs +: COORD_W];
            res_y_reg <= accy_flat[pix_ofs +: COORD_W];
        end
    end

    assign res_valid        = res_valid_reg;
    assign res_data.curve_x = res_x_reg;
    assign res_data.curve_y = res_y_reg;
    assign stat.deg         = deg_reg;
    assign stat.out_free    = !res_valid_reg || res_ready;

endmodule

### rtl/bezier_curve_point_evaluator.sv
// A load transfer writes its control point straight into the store. An evaluate transfer
// with d = point_count - 1 builds the Pascal row, then for each k = 0..d sets up one coefficient
// and runs floor(k/2) + 2 limbs through the limb-serial Horner loop (one limb a cycle).
// One item is in work at a time; a new item is taken while a result waits for transfer.
// rst_n is asynchronous active low: controller idles, point_count returns to 2,
// the result register empties; the control point store holds garbage until loaded.
module bezier_curve_point_evaluator #(
    parameter int MAX_POINTS = 16
) (
    input logic       clk,
    input logic       rst_n,
    bcpe_req_if.sink  request,
    bcpe_res_if.source result,
    bcpe_cfg_if.sink  setup
);
    import bcpe_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Setup register is always writable
    assign setup.ready = 1'b1;

    bcpe_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_kind  (request.data.kind),
        .req_ready (request.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bcpe_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req_data  (request.data),
        .cfg_we    (setup.valid),
        .cfg_data  (setup.data),
        .res_ready (result.ready),
        .res_valid (result.valid),
        .res_data  (result.data)
    );

endmodule
